// ===== src/rpdl_pkg.sv =====
package rpdl_pkg;

   localparam int MAX_SAMPLES = 2048;
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int MIN_PTS     = 4;
   localparam int MAX_PTS     = 20;
   localparam int CNT_W       = 5;
   localparam int COUNT_SAT   = (1 << CNT_W) - 1;
   localparam int RANGE_W     = 16;
   localparam int SUM_W       = 21;
   localparam int ANG_W       = 16;
   localparam int POS_W       = IDX_W + 2;
   localparam int PROD_W      = POS_W + ANG_W;

   localparam int CORDIC_N    = 20;
   localparam int ITER_W      = 5;
   localparam int XY_W        = 36;
   localparam int Z_W         = 26;
   localparam int P_W         = 24;
   localparam int SQ_W        = 2 * P_W;
   localparam int ACC_W       = 50;
   localparam int ROOT_W      = ACC_W / 2;
   localparam int REM_W       = ROOT_W + 1;
   localparam int SQ_STEPS    = 6;
   localparam int GAIN        = 39797;
   localparam int POINT_SHIFT = 12;

   localparam logic signed [Z_W-1:0] QUARTER_T = 26'sd4194304;
   localparam logic signed [Z_W-1:0] HALF_T    = 26'sd8388608;
   localparam logic signed [Z_W-1:0] ROUND_Z   = 26'sd128;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_MAX_RANGE = 3'd0;
   localparam logic [2:0] REG_MAX_GAP   = 3'd1;
   localparam logic [2:0] REG_START_ANG = 3'd2;
   localparam logic [2:0] REG_ANG_STEP  = 3'd3;
   localparam logic [2:0] REG_PAIR_SEP  = 3'd4;
   localparam logic [2:0] REG_SEP_TOL   = 3'd5;
   localparam logic [2:0] REG_BEAR_LIM  = 3'd6;
   localparam logic [2:0] REG_HOLD      = 3'd7;

   // squarer operand selects
   localparam logic [2:0] SQ_DX = 3'd0;
   localparam logic [2:0] SQ_DY = 3'd1;
   localparam logic [2:0] SQ_HI = 3'd2;
   localparam logic [2:0] SQ_LO = 3'd3;
   localparam logic [2:0] SQ_SX = 3'd4;
   localparam logic [2:0] SQ_SY = 3'd5;

   typedef struct packed {
      logic [15:0]        max_range_mm;
      logic [15:0]        max_gap_mm;
      logic signed [15:0] start_angle;
      logic [15:0]        angle_step;
      logic [15:0]        pair_separation_mm;
      logic [15:0]        separation_tolerance_mm;
      logic [14:0]        bearing_limit;
      logic [15:0]        hold_ms;
   } cfg_type;

   typedef struct packed {
      logic       accept;
      logic       div_start;
      logic       div_step;
      logic       side_update;
      logic       end_close;
      logic       rot_load_left;
      logic       rot_load_right;
      logic       cordic_step;
      logic       geo_prep;
      logic       sq_step;
      logic [2:0] sq_sel;
      logic       root_load;
      logic       root_step;
      logic       vec_load;
      logic       decide;
      logic [ITER_W-1:0] iter;
   } cmd_type;

   typedef struct packed {
      logic close_pend;
      logic last;
      logic both_found;
      logic rsp_free;
   } stat_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = 26'sd2097152;
         5'd1:    v = 26'sd1238021;
         5'd2:    v = 26'sd654136;
         5'd3:    v = 26'sd332050;
         5'd4:    v = 26'sd166669;
         5'd5:    v = 26'sd83416;
         5'd6:    v = 26'sd41718;
         5'd7:    v = 26'sd20860;
         5'd8:    v = 26'sd10430;
         5'd9:    v = 26'sd5215;
         5'd10:   v = 26'sd2608;
         5'd11:   v = 26'sd1304;
         5'd12:   v = 26'sd652;
         5'd13:   v = 26'sd326;
         5'd14:   v = 26'sd163;
         5'd15:   v = 26'sd81;
         5'd16:   v = 26'sd41;
         5'd17:   v = 26'sd20;
         5'd18:   v = 26'sd10;
         5'd19:   v = 26'sd5;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/rpdl_if.sv =====
interface rpdl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_mm;
   logic        range_finite;
   logic        last_sample;
   logic [31:0] now_ms;

   modport source(output valid, range_mm, range_finite, last_sample, now_ms, input ready);
   modport sink(input valid, range_mm, range_finite, last_sample, now_ms, output ready);
endinterface

interface rpdl_rsp_if;
   logic               valid;
   logic               ready;
   logic               target_valid;
   logic [15:0]        distance_mm;
   logic signed [15:0] bearing;

   modport source(output valid, target_valid, distance_mm, bearing, input ready);
   modport sink(input valid, target_valid, distance_mm, bearing, output ready);
endinterface

// ===== src/reflector_pair_dock_locator.sv =====
// Reflector pair dock locator.
// req_ch carries one laser range transaction per sample (range_mm, range_finite,
// last_sample, now_ms); rsp_ch carries one result transaction per scan, raised
// after the transaction that has last_sample set. Both use valid/ready.
// The APB port (psel..pready) sets the eight thresholds; write it only while idle.
// A sample that closes no cluster passes S_IDLE and S_PEND; closing a cluster also
// runs the 21-step restoring divider that forms the mean range. No new sample is
// taken until the last one is through. Scan end closes the open run and then runs
// the shared CORDIC (two rotations of 20 steps, one 20-step vectoring pass), six
// squarings on one multiplier and a 25-step square root, to the result.
// With either side lacking a cluster the geometry is skipped.
// Reset (synchronous, active high) restores the register defaults, clears the
// scan, the held target and the result register.
// A stalled receiver holds the result in the output register; the block keeps
// taking samples, and only a scan end waits until the register is free.
module reflector_pair_dock_locator (
   input  logic        clock,
   input  logic        reset,
   rpdl_req_if.sink    req_ch,
   rpdl_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   rpdl_pkg::cfg_type  cfg;
   rpdl_pkg::cmd_type  cmd;
   rpdl_pkg::stat_type st;
   logic               req_ready;

   assign req_ch.ready = req_ready;

   // register file
   rpdl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: steps samples, cluster closes and scan-end geometry
   rpdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // run tracking, divider, CORDIC, squarer, root and result register
   rpdl_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .st               (st),
      .range_mm         (req_ch.range_mm),
      .range_finite     (req_ch.range_finite),
      .last_sample      (req_ch.last_sample),
      .now_ms           (req_ch.now_ms),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_target_valid (rsp_ch.target_valid),
      .rsp_distance_mm  (rsp_ch.distance_mm),
      .rsp_bearing      (rsp_ch.bearing)
   );

endmodule

// ===== src/rpdl_csr.sv =====
module rpdl_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output rpdl_pkg::cfg_type cfg
);

   rpdl_pkg::cfg_type cfg_ff;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_range_mm            <= 16'd600;
         cfg_ff.max_gap_mm              <= 16'd60;
         cfg_ff.start_angle             <= -16'sd32768;
         cfg_ff.angle_step              <= 16'd182;
         cfg_ff.pair_separation_mm      <= 16'd238;
         cfg_ff.separation_tolerance_mm <= 16'd50;
         cfg_ff.bearing_limit           <= 15'd5461;
         cfg_ff.hold_ms                 <= 16'd150;
      end else if (wr_en) begin
         case (paddr[4:2])
            rpdl_pkg::REG_MAX_RANGE: cfg_ff.max_range_mm            <= pwdata[15:0];
            rpdl_pkg::REG_MAX_GAP:   cfg_ff.max_gap_mm              <= pwdata[15:0];
            rpdl_pkg::REG_START_ANG: cfg_ff.start_angle             <= pwdata[15:0];
            rpdl_pkg::REG_ANG_STEP:  cfg_ff.angle_step              <= pwdata[15:0];
            rpdl_pkg::REG_PAIR_SEP:  cfg_ff.pair_separation_mm      <= pwdata[15:0];
            rpdl_pkg::REG_SEP_TOL:   cfg_ff.separation_tolerance_mm <= pwdata[15:0];
            rpdl_pkg::REG_BEAR_LIM:  cfg_ff.bearing_limit           <= pwdata[14:0];
            rpdl_pkg::REG_HOLD:      cfg_ff.hold_ms                 <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         rpdl_pkg::REG_MAX_RANGE: prdata = {16'd0, cfg_ff.max_range_mm};
         rpdl_pkg::REG_MAX_GAP:   prdata = {16'd0, cfg_ff.max_gap_mm};
         rpdl_pkg::REG_START_ANG: prdata = {16'd0, cfg_ff.start_angle};
         rpdl_pkg::REG_ANG_STEP:  prdata = {16'd0, cfg_ff.angle_step};
         rpdl_pkg::REG_PAIR_SEP:  prdata = {16'd0, cfg_ff.pair_separation_mm};
         rpdl_pkg::REG_SEP_TOL:   prdata = {16'd0, cfg_ff.separation_tolerance_mm};
         rpdl_pkg::REG_BEAR_LIM:  prdata = {17'd0, cfg_ff.bearing_limit};
         rpdl_pkg::REG_HOLD:      prdata = {16'd0, cfg_ff.hold_ms};
         default:                 prdata = '0;
      endcase
   end

endmodule

// ===== src/rpdl_ctrl.sv =====
module rpdl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rpdl_pkg::stat_type st,
   output rpdl_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_PEND, S_DIV, S_SIDE, S_ENDRUN, S_GEO, S_ROT_L, S_LOAD_R,
      S_ROT_R, S_PREP, S_SQ, S_ROOT_LD, S_SQRT, S_VEC_LD, S_VEC, S_DECIDE
   } state_type;

   state_type                     state_ff, state_in;
   logic [rpdl_pkg::ITER_W-1:0]   iter_ff, iter_in;
   logic                          end_done_ff, end_done_in;
   logic                          iter_last_div, iter_last_cordic, iter_last_sq, iter_last_root;

   assign iter_last_div    = (iter_ff == rpdl_pkg::ITER_W'(rpdl_pkg::SUM_W - 1));
   assign iter_last_cordic = (iter_ff == rpdl_pkg::ITER_W'(rpdl_pkg::CORDIC_N - 1));
   assign iter_last_sq     = (iter_ff == rpdl_pkg::ITER_W'(rpdl_pkg::SQ_STEPS - 1));
   assign iter_last_root   = (iter_ff == rpdl_pkg::ITER_W'(rpdl_pkg::ROOT_W - 1));
   assign req_ready        = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      end_done_in = end_done_ff;
      cmd         = '0;
      cmd.iter    = iter_ff;
      cmd.sq_sel  = iter_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept  = 1'b1;
               end_done_in = 1'b0;
               state_in    = S_PEND;
            end
         end
         S_PEND: begin
            if (st.close_pend) begin
               cmd.div_start = 1'b1;
               iter_in       = '0;
               state_in      = S_DIV;
            end else if (!st.last) begin
               state_in = S_IDLE;
            end else if (!end_done_ff) begin
               state_in = S_ENDRUN;
            end else begin
               state_in = S_GEO;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_last_div) begin
               state_in = S_SIDE;
            end
         end
         S_SIDE: begin
            cmd.side_update = 1'b1;
            state_in        = S_PEND;
         end
         S_ENDRUN: begin
            cmd.end_close = 1'b1;
            end_done_in   = 1'b1;
            state_in      = S_PEND;
         end
         S_GEO: begin
            iter_in = '0;
            if (st.both_found) begin
               cmd.rot_load_left = 1'b1;
               state_in          = S_ROT_L;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_ROT_L: begin
            cmd.cordic_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
            if (iter_last_cordic) begin
               state_in = S_LOAD_R;
            end
         end
         S_LOAD_R: begin
            cmd.rot_load_right = 1'b1;
            iter_in            = '0;
            state_in           = S_ROT_R;
         end
         S_ROT_R: begin
            cmd.cordic_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
            if (iter_last_cordic) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.geo_prep = 1'b1;
            iter_in      = '0;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            iter_in     = iter_ff + 1'b1;
            if (iter_last_sq) begin
               state_in = S_ROOT_LD;
            end
         end
         S_ROOT_LD: begin
            cmd.root_load = 1'b1;
            iter_in       = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.root_step = 1'b1;
            iter_in       = iter_ff + 1'b1;
            if (iter_last_root) begin
               state_in = S_VEC_LD;
            end
         end
         S_VEC_LD: begin
            cmd.vec_load = 1'b1;
            iter_in      = '0;
            state_in     = S_VEC;
         end
         S_VEC: begin
            cmd.cordic_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
            if (iter_last_cordic) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.rsp_free) begin
               cmd.decide = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         iter_ff     <= '0;
         end_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         iter_ff     <= iter_in;
         end_done_ff <= end_done_in;
      end
   end

endmodule

// ===== src/rpdl_dpath.sv =====
module rpdl_dpath (
   input  logic               clock,
   input  logic               reset,
   input  rpdl_pkg::cfg_type  cfg,
   input  rpdl_pkg::cmd_type  cmd,
   output rpdl_pkg::stat_type st,
   input  logic [15:0]        range_mm,
   input  logic               range_finite,
   input  logic               last_sample,
   input  logic [31:0]        now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_target_valid,
   output logic [15:0]        rsp_distance_mm,
   output logic signed [15:0] rsp_bearing
);

   localparam int IDX_W  = rpdl_pkg::IDX_W;
   localparam int CNT_W  = rpdl_pkg::CNT_W;
   localparam int SUM_W  = rpdl_pkg::SUM_W;
   localparam int XY_W   = rpdl_pkg::XY_W;
   localparam int Z_W    = rpdl_pkg::Z_W;
   localparam int P_W    = rpdl_pkg::P_W;
   localparam int SQ_W   = rpdl_pkg::SQ_W;
   localparam int ACC_W  = rpdl_pkg::ACC_W;
   localparam int ROOT_W = rpdl_pkg::ROOT_W;
   localparam int REM_W  = rpdl_pkg::REM_W;
   localparam int POS_W  = rpdl_pkg::POS_W;
   localparam int PROD_W = rpdl_pkg::PROD_W;

   // sample and run state
   logic [IDX_W-1:0] idx_ff;
   logic             run_active_ff;
   logic [IDX_W-1:0] run_start_ff;
   logic [CNT_W-1:0] run_count_ff;
   logic [SUM_W-1:0] run_sum_ff;
   logic [15:0]      prev_ff;
   logic             last_ff;
   logic [31:0]      now_ff;

   // pending cluster and divider
   logic             close_pend_ff;
   logic [IDX_W-1:0] c_start_ff;
   logic [CNT_W-1:0] c_count_ff;
   logic [SUM_W-1:0] div_num_ff;
   logic [CNT_W-1:0] div_rem_ff;

   // nearest cluster on each side
   logic        left_found_ff, right_found_ff;
   logic [15:0] left_range_ff, right_range_ff;
   logic [15:0] left_angle_ff, right_angle_ff;

   // shared CORDIC and geometry
   logic signed [XY_W-1:0] cx_ff, cy_ff;
   logic signed [Z_W-1:0]  cz_ff;
   logic                   rot_mode_ff;
   logic signed [P_W-1:0]  x1_ff, y1_ff, dx_ff, dy_ff, sx_ff, sy_ff;
   logic [16:0]            hi_base_ff;
   logic signed [17:0]     lo_ff;
   logic [ACC_W-1:0]       d2_ff, hi2_ff, lo2_ff, s2_ff, root_src_ff;
   logic                   sep_ok_ff, vec_zero_ff;
   logic [REM_W-1:0]       root_rem_ff;
   logic [ROOT_W-1:0]      root_ff;

   // held target and result
   logic               held_valid_ff;
   logic [15:0]        held_dist_ff;
   logic [15:0]        held_bear_ff;
   logic [31:0]        last_time_ff;
   logic               rsp_valid_ff, rsp_tv_ff;
   logic [15:0]        rsp_dist_ff;
   logic [15:0]        rsp_bear_ff;

   // ---------------- sample combinational ----------------
   logic             samp_ok, split, close_now;
   logic [15:0]      gap;
   logic             run_in_range, end_in_range;

   assign samp_ok      = range_finite && (range_mm < cfg.max_range_mm);
   assign gap          = (range_mm > prev_ff) ? (range_mm - prev_ff) : (prev_ff - range_mm);
   assign split        = run_active_ff && (gap > cfg.max_gap_mm);
   assign close_now    = samp_ok ? split : run_active_ff;
   assign run_in_range = (run_count_ff >= CNT_W'(rpdl_pkg::MIN_PTS)) &&
                         (run_count_ff <= CNT_W'(rpdl_pkg::MAX_PTS));
   assign end_in_range = run_active_ff && run_in_range;

   // ---------------- divider step ----------------
   logic [CNT_W:0] div_sh;
   logic           div_ge;

   assign div_sh = {div_rem_ff, div_num_ff[SUM_W-1]};
   assign div_ge = (div_sh >= {1'b0, c_count_ff});

   // ---------------- cluster angle ----------------
   logic [POS_W-1:0]  pos_sum;
   logic [PROD_W-1:0] pos_prod;
   logic [15:0]       clu_ang, clu_mean;
   logic              clu_left;

   assign pos_sum  = {1'b0, c_start_ff, 1'b0} + POS_W'(c_count_ff) - POS_W'(1);
   assign pos_prod = PROD_W'(pos_sum) * PROD_W'(cfg.angle_step);
   assign clu_ang  = cfg.start_angle + pos_prod[16:1];
   assign clu_mean = div_num_ff[15:0];
   assign clu_left = (clu_ang != 16'd0) && !clu_ang[15];

   // ---------------- polar load ----------------
   logic [15:0]            ld_range, ld_angle;
   logic signed [Z_W-1:0]  ld_z;
   logic signed [XY_W-1:0] ld_x;
   logic [31:0]            ld_scaled;

   assign ld_range  = cmd.rot_load_left ? left_range_ff : right_range_ff;
   assign ld_angle  = cmd.rot_load_left ? left_angle_ff : right_angle_ff;
   assign ld_z      = {{(Z_W-24){ld_angle[15]}}, ld_angle, 8'd0};
   assign ld_scaled = 32'(ld_range) * 32'(rpdl_pkg::GAIN);
   assign ld_x      = XY_W'(ld_scaled);

   // ---------------- CORDIC step ----------------
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  at;
   logic                   dir;
   logic signed [XY_W-1:0] pt_x, pt_y;

   assign xs   = cx_ff >>> cmd.iter;
   assign ys   = cy_ff >>> cmd.iter;
   assign at   = rpdl_pkg::atan_entry(cmd.iter);
   assign dir  = rot_mode_ff ? !cz_ff[Z_W-1] : !(cy_ff > 0);
   assign pt_x = cx_ff >>> rpdl_pkg::POINT_SHIFT;
   assign pt_y = cy_ff >>> rpdl_pkg::POINT_SHIFT;

   // ---------------- squarer ----------------
   logic signed [P_W-1:0] sq_op;
   logic signed [SQ_W-1:0] sq_res;
   logic [ACC_W-1:0]      sq_ext, sq_sh;

   always_comb begin
      case (cmd.sq_sel)
         rpdl_pkg::SQ_DX: sq_op = dx_ff;
         rpdl_pkg::SQ_DY: sq_op = dy_ff;
         rpdl_pkg::SQ_HI: sq_op = P_W'(hi_base_ff);
         rpdl_pkg::SQ_LO: sq_op = P_W'(lo_ff);
         rpdl_pkg::SQ_SX: sq_op = sx_ff;
         rpdl_pkg::SQ_SY: sq_op = sy_ff;
         default:         sq_op = '0;
      endcase
   end

   assign sq_res = sq_op * sq_op;
   assign sq_ext = ACC_W'(unsigned'(sq_res));
   assign sq_sh  = sq_ext << 8;

   // ---------------- square root step ----------------
   logic [REM_W+1:0] rt_t, rt_trial;
   logic             rt_ge;

   assign rt_t     = {root_rem_ff, root_src_ff[ACC_W-1 -: 2]};
   assign rt_trial = {1'b0, root_ff, 2'b01};
   assign rt_ge    = (rt_t >= rt_trial);

   // ---------------- decision ----------------
   logic signed [Z_W-1:0] z_rnd;
   logic [15:0]           bear;
   logic [16:0]           bear_mag;
   logic [ROOT_W:0]       dist_full;
   logic [15:0]           dist_sat;
   logic                  fresh, in_hold;

   assign z_rnd     = cz_ff + rpdl_pkg::ROUND_Z;
   assign bear      = vec_zero_ff ? 16'd0 : z_rnd[23:8];
   assign bear_mag  = bear[15] ? (17'd0 - {1'b1, bear}) : {1'b0, bear};
   assign dist_full = {1'b0, root_ff} + (ROOT_W + 1)'(16);
   assign dist_sat  = (|dist_full[ROOT_W:21]) ? 16'hFFFF : dist_full[20:5];
   assign fresh     = left_found_ff && right_found_ff && sep_ok_ff &&
                      (bear_mag < {2'b00, cfg.bearing_limit});
   assign in_hold   = ((now_ff - last_time_ff) < {16'd0, cfg.hold_ms});

   // ---------------- status and outputs ----------------
   assign st.close_pend = close_pend_ff;
   assign st.last       = last_ff;
   assign st.both_found = left_found_ff && right_found_ff;
   assign st.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_valid = rsp_tv_ff;
   assign rsp_distance_mm  = rsp_dist_ff;
   assign rsp_bearing      = rsp_bear_ff;

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         run_active_ff  <= 1'b0;
         run_start_ff   <= '0;
         run_count_ff   <= '0;
         run_sum_ff     <= '0;
         prev_ff        <= '0;
         last_ff        <= 1'b0;
         close_pend_ff  <= 1'b0;
         left_found_ff  <= 1'b0;
         right_found_ff <= 1'b0;
         left_range_ff  <= '0;
         right_range_ff <= '0;
         left_angle_ff  <= '0;
         right_angle_ff <= '0;
         held_valid_ff  <= 1'b0;
         held_dist_ff   <= '0;
         held_bear_ff   <= '0;
         last_time_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (close_now && run_in_range) begin
               close_pend_ff <= 1'b1;
            end
            if (!samp_ok) begin
               run_active_ff <= 1'b0;
            end else if (!run_active_ff || split) begin
               run_active_ff <= 1'b1;
               run_start_ff  <= idx_ff;
               run_count_ff  <= CNT_W'(1);
               run_sum_ff    <= SUM_W'(range_mm);
            end else if (run_count_ff < CNT_W'(rpdl_pkg::COUNT_SAT)) begin
               run_count_ff <= run_count_ff + 1'b1;
               run_sum_ff   <= run_sum_ff + SUM_W'(range_mm);
            end
            prev_ff <= range_mm;
            last_ff <= last_sample;
            if (!last_sample) begin
               idx_ff <= (idx_ff == IDX_W'(rpdl_pkg::MAX_SAMPLES - 1)) ? '0 : idx_ff + 1'b1;
            end
         end
         if (cmd.end_close) begin
            run_active_ff <= 1'b0;
            if (end_in_range) begin
               close_pend_ff <= 1'b1;
            end
         end
         if (cmd.side_update) begin
            close_pend_ff <= 1'b0;
            if (clu_left) begin
               if (!left_found_ff || clu_mean < left_range_ff) begin
                  left_found_ff <= 1'b1;
                  left_range_ff <= clu_mean;
                  left_angle_ff <= clu_ang;
               end
            end else if (!right_found_ff || clu_mean < right_range_ff) begin
               right_found_ff <= 1'b1;
               right_range_ff <= clu_mean;
               right_angle_ff <= clu_ang;
            end
         end
         if (cmd.decide) begin
            rsp_valid_ff <= 1'b1;
            if (fresh) begin
               held_valid_ff <= 1'b1;
               held_dist_ff  <= dist_sat;
               held_bear_ff  <= bear;
               last_time_ff  <= now_ff;
            end
            // clear the scan for the next one
            idx_ff         <= '0;
            run_active_ff  <= 1'b0;
            run_start_ff   <= '0;
            run_count_ff   <= '0;
            run_sum_ff     <= '0;
            last_ff        <= 1'b0;
            left_found_ff  <= 1'b0;
            right_found_ff <= 1'b0;
            left_range_ff  <= '0;
            right_range_ff <= '0;
            left_angle_ff  <= '0;
            right_angle_ff <= '0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         now_ff <= now_ms;
         if (close_now) begin
            c_start_ff <= run_start_ff;
            c_count_ff <= run_count_ff;
            div_num_ff <= run_sum_ff;
         end
      end
      if (cmd.end_close) begin
         c_start_ff <= run_start_ff;
         c_count_ff <= run_count_ff;
         div_num_ff <= run_sum_ff;
      end
      if (cmd.div_start) begin
         div_rem_ff <= '0;
      end
      if (cmd.div_step) begin
         div_rem_ff <= div_ge ? CNT_W'(div_sh - {1'b0, c_count_ff}) : div_sh[CNT_W-1:0];
         div_num_ff <= {div_num_ff[SUM_W-2:0], div_ge};
      end
      if (cmd.rot_load_left || cmd.rot_load_right) begin
         rot_mode_ff <= 1'b1;
         cy_ff       <= '0;
         if (ld_z > rpdl_pkg::QUARTER_T) begin
            cx_ff <= -ld_x;
            cz_ff <= ld_z - rpdl_pkg::HALF_T;
         end else if (ld_z < -rpdl_pkg::QUARTER_T) begin
            cx_ff <= -ld_x;
            cz_ff <= ld_z + rpdl_pkg::HALF_T;
         end else begin
            cx_ff <= ld_x;
            cz_ff <= ld_z;
         end
      end
      if (cmd.rot_load_right) begin
         x1_ff <= P_W'(pt_x);
         y1_ff <= P_W'(pt_y);
      end
      if (cmd.cordic_step) begin
         if (dir) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - at;
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + at;
         end
      end
      if (cmd.geo_prep) begin
         dx_ff      <= x1_ff - P_W'(pt_x);
         dy_ff      <= y1_ff - P_W'(pt_y);
         sx_ff      <= x1_ff + P_W'(pt_x);
         sy_ff      <= y1_ff + P_W'(pt_y);
         hi_base_ff <= {1'b0, cfg.pair_separation_mm} + {1'b0, cfg.separation_tolerance_mm};
         lo_ff      <= {2'b00, cfg.pair_separation_mm} - {2'b00, cfg.separation_tolerance_mm};
      end
      if (cmd.sq_step) begin
         case (cmd.sq_sel)
            rpdl_pkg::SQ_DX: d2_ff  <= sq_ext;
            rpdl_pkg::SQ_DY: d2_ff  <= d2_ff + sq_ext;
            rpdl_pkg::SQ_HI: hi2_ff <= sq_sh;
            rpdl_pkg::SQ_LO: lo2_ff <= sq_sh;
            rpdl_pkg::SQ_SX: s2_ff  <= sq_ext;
            rpdl_pkg::SQ_SY: s2_ff  <= s2_ff + sq_ext;
            default: ;
         endcase
      end
      if (cmd.root_load) begin
         sep_ok_ff   <= (d2_ff < hi2_ff) && (lo_ff[17] || (d2_ff > lo2_ff));
         root_src_ff <= s2_ff;
         root_rem_ff <= '0;
         root_ff     <= '0;
      end
      if (cmd.root_step) begin
         root_src_ff <= root_src_ff << 2;
         root_rem_ff <= rt_ge ? REM_W'(rt_t - rt_trial) : rt_t[REM_W-1:0];
         root_ff     <= {root_ff[ROOT_W-2:0], rt_ge};
      end
      if (cmd.vec_load) begin
         rot_mode_ff <= 1'b0;
         vec_zero_ff <= (sx_ff == '0) && (sy_ff == '0);
         if (sx_ff < 0) begin
            cx_ff <= -XY_W'(sx_ff);
            cy_ff <= -XY_W'(sy_ff);
            cz_ff <= rpdl_pkg::HALF_T;
         end else begin
            cx_ff <= XY_W'(sx_ff);
            cy_ff <= XY_W'(sy_ff);
            cz_ff <= '0;
         end
      end
      if (cmd.decide) begin
         if (fresh) begin
            rsp_tv_ff   <= 1'b1;
            rsp_dist_ff <= dist_sat;
            rsp_bear_ff <= bear;
         end else if (in_hold) begin
            rsp_tv_ff   <= held_valid_ff;
            rsp_dist_ff <= held_dist_ff;
            rsp_bear_ff <= held_bear_ff;
         end else begin
            rsp_tv_ff   <= 1'b0;
            rsp_dist_ff <= '0;
            rsp_bear_ff <= '0;
         end
      end
   end

endmodule

// ===== src/rpdl_checker.sv =====
module rpdl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_target_valid,
   input logic [15:0] rsp_distance_mm,
   input logic [15:0] rsp_bearing
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target_valid) &&
      $stable(rsp_distance_mm) && $stable(rsp_bearing))
      else $error("result changed while stalled");

   // no target means zero fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_target_valid |-> rsp_distance_mm == 16'd0 && rsp_bearing == 16'd0)
      else $error("invalid target with nonzero fields");

   // result register empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind reflector_pair_dock_locator rpdl_checker u_rpdl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_target_valid (rsp_ch.target_valid),
   .rsp_distance_mm  (rsp_ch.distance_mm),
   .rsp_bearing      (rsp_ch.bearing)
);

// ===== bench/tb_reflector_pair_dock_locator.sv =====
module tb_reflector_pair_dock_locator;
   import rpdl_pkg::*;

   localparam int STALL_LIMIT = 20000;   // cycles with no transaction before giving up
   localparam int SETTLE      = 200;     // covers cluster closes plus the scan-end geometry

   typedef struct packed {
      logic               target_valid;
      logic [15:0]        distance_mm;
      logic signed [15:0] bearing;
   } dock_result_type;

   typedef struct packed {
      logic [15:0]     range_mm;
      logic            finite;
      logic            last;
      logic [31:0]     now_ms;
      logic            typed;
      dock_result_type res;
   } dock_row_type;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   rpdl_req_if req_bus();
   rpdl_rsp_if rsp_bus();

   reflector_pair_dock_locator dut (
      .clock(clock), .reset(reset),
      .req_ch(req_bus), .rsp_ch(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // register mirror and scan state of the predictor
   cfg_type     regs;
   int unsigned scan_pos, run_first, run_len, run_total;
   logic [15:0] prev_mm;
   bit          run_open;
   bit          left_ok, right_ok, hold_ok;
   logic [15:0] left_mm, left_ang, right_mm, right_ang, hold_dist, hold_bear;
   logic [31:0] hold_stamp;

   dock_result_type expected_docks[$];
   int          mismatches;
   int          sent;
   int          idle_cycles;
   int          rx_wait, rx_hold;
   bit          steady_tx, steady_rx;
   logic [31:0] clock_ms;

   const int atan_steps[CORDIC_N] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430, 5215,
      2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Rotate (r,0) by a binary angle; results in Q4 mm.
   task automatic rotate_point(input logic [15:0] r, input logic [15:0] ang,
                               output longint xo, output longint yo);
      longint x, y, xs, ys;
      int     z;
      x = longint'(r) * GAIN;
      y = 0;
      z = int'($signed(ang)) * 256;
      // fold into the right half-plane first
      if (z > int'(QUARTER_T)) begin
         x = -x; z -= int'(HALF_T);
      end else if (z < -int'(QUARTER_T)) begin
         x = -x; z += int'(HALF_T);
      end
      for (int i = 0; i < CORDIC_N; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_steps[i];
         end else begin
            x += ys; y -= xs; z += atan_steps[i];
         end
      end
      xo = x >>> POINT_SHIFT;
      yo = y >>> POINT_SHIFT;
   endtask

   function automatic logic [15:0] midpoint_bearing(input longint xi, input longint yi);
      longint      x, y, xs, ys;
      int          z;
      logic [31:0] zr;
      x = xi; y = yi; z = 0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
         x = -x; y = -y; z = int'(HALF_T);
      end
      for (int i = 0; i < CORDIC_N; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += atan_steps[i];
         end else begin
            x -= ys; y += xs; z -= atan_steps[i];
         end
      end
      zr = z + 128;
      return zr[23:8];
   endfunction

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned rem, res, bit_pos;
      rem = v; res = 0; bit_pos = 64'd1 << 62;
      while (bit_pos > rem) bit_pos >>= 2;
      while (bit_pos != 0) begin
         if (rem >= res + bit_pos) begin
            rem -= res + bit_pos; res = (res >> 1) + bit_pos;
         end else begin
            res >>= 1;
         end
         bit_pos >>= 2;
      end
      return res;
   endfunction

   task automatic close_cluster();
      int unsigned mean, pos, ang;
      if (!run_open) return;
      run_open = 0;
      if (run_len < MIN_PTS || run_len > MAX_PTS) return;
      mean = run_total / run_len;
      pos  = 2 * run_first + run_len - 1;
      ang  = ({16'h0, regs.start_angle} + ((pos * regs.angle_step) >> 1)) & 32'hFFFF;
      // strictly positive angles are the left reflector; -32768 falls right
      if (ang >= 1 && ang <= 32767) begin
         if (!left_ok || mean < left_mm) begin
            left_ok = 1; left_mm = mean[15:0]; left_ang = ang[15:0];
         end
      end else if (!right_ok || mean < right_mm) begin
         right_ok = 1; right_mm = mean[15:0]; right_ang = ang[15:0];
      end
   endtask

   task automatic locate_pair(output bit found, output logic [15:0] dist_est,
                              output logic [15:0] bear);
      longint          x1, y1, x2, y2, dx, dy, sx, sy, lo;
      longint unsigned d2, hi, dd;
      int              bs, mag;
      found = 0; dist_est = 0; bear = 0;
      if (!left_ok || !right_ok) return;
      rotate_point(left_mm, left_ang, x1, y1);
      rotate_point(right_mm, right_ang, x2, y2);
      dx = x1 - x2; dy = y1 - y2;
      d2 = dx * dx + dy * dy;
      hi = longint'(regs.pair_separation_mm) + longint'(regs.separation_tolerance_mm);
      hi = hi * hi * 256;
      lo = longint'(regs.pair_separation_mm) - longint'(regs.separation_tolerance_mm);
      if (!(d2 < hi)) return;
      // a negative lower bound leaves only the upper one
      if (lo >= 0 && !(d2 > longint'(lo * lo) * 256)) return;
      sx = x1 + x2; sy = y1 + y2;
      dd = (int_root(sx * sx + sy * sy) + 16) >> 5;
      if (dd > 65535) dd = 65535;
      bear = midpoint_bearing(sx, sy);
      bs   = int'($signed(bear));
      mag  = bs < 0 ? -bs : bs;
      if (!(mag < int'(regs.bearing_limit))) return;
      dist_est = dd[15:0];
      found    = 1;
   endtask

   task automatic predict_sample(input logic [15:0] rng, input logic fin, input logic last,
                                 input logic [31:0] now, output bit emits,
                                 output dock_result_type res);
      logic [15:0] gap, dist_est, bear;
      logic [31:0] age;
      bit          fresh;
      res = '0; emits = 0;
      if (!(fin && rng < regs.max_range_mm)) begin
         close_cluster();
      end else begin
         gap = rng > prev_mm ? rng - prev_mm : prev_mm - rng;
         if (run_open && gap > regs.max_gap_mm) close_cluster();
         if (!run_open) begin
            run_open = 1; run_first = scan_pos; run_len = 1; run_total = rng;
         end else if (run_len < COUNT_SAT) begin
            run_len++; run_total += rng;
         end
      end
      prev_mm = rng;
      if (!last) begin
         // index wraps; an open run keeps its start
         scan_pos = (scan_pos + 1 >= MAX_SAMPLES) ? 0 : scan_pos + 1;
         return;
      end
      close_cluster();
      locate_pair(fresh, dist_est, bear);
      age = now - hold_stamp;
      if (fresh) begin
         hold_ok = 1; hold_dist = dist_est; hold_bear = bear; hold_stamp = now;
         res = '{1'b1, dist_est, bear};
      end else if (age < regs.hold_ms) begin
         res = '{hold_ok, hold_dist, hold_bear};
      end
      emits = 1;
      scan_pos = 0; run_open = 0; run_first = 0; run_len = 0; run_total = 0;
      left_ok = 0; left_mm = 0; left_ang = 0;
      right_ok = 0; right_mm = 0; right_ang = 0;
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      case (idx)
         REG_MAX_RANGE: regs.max_range_mm            = val;
         REG_MAX_GAP:   regs.max_gap_mm              = val;
         REG_START_ANG: regs.start_angle             = val;
         REG_ANG_STEP:  regs.angle_step              = val;
         REG_PAIR_SEP:  regs.pair_separation_mm      = val;
         REG_SEP_TOL:   regs.separation_tolerance_mm = val;
         REG_BEAR_LIM:  regs.bearing_limit           = val[14:0];
         REG_HOLD:      regs.hold_ms                 = val;
         default: ;
      endcase
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic write_all(input logic [15:0] rmax, input logic [15:0] gap,
                            input logic [15:0] start, input logic [15:0] step,
                            input logic [15:0] sep, input logic [15:0] tol,
                            input logic [15:0] blim, input logic [15:0] hold);
      reg_write(REG_MAX_RANGE, rmax);
      reg_write(REG_MAX_GAP, gap);
      reg_write(REG_START_ANG, start);
      reg_write(REG_ANG_STEP, step);
      reg_write(REG_PAIR_SEP, sep);
      reg_write(REG_SEP_TOL, tol);
      reg_write(REG_BEAR_LIM, blim);
      reg_write(REG_HOLD, hold);
   endtask

   // Offer one sample; hold valid until the handshake, then predict.
   task automatic send_sample(input logic [15:0] rng, input logic fin, input logic last,
                              input logic [31:0] now, input logic typed,
                              input dock_result_type typed_res);
      int              gap;
      bit              emits;
      dock_result_type res;
      gap = steady_tx ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 0;
      end
      @(negedge clock);
      req_bus.valid        <= 1;
      req_bus.range_mm     <= rng;
      req_bus.range_finite <= fin;
      req_bus.last_sample  <= last;
      req_bus.now_ms       <= now;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
      predict_sample(rng, fin, last, now, emits, res);
      if (emits) expected_docks.insert(expected_docks.size(), typed ? typed_res : res);
   endtask

   // Let every expected result arrive, then let the block settle before a write.
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 0;
      while (expected_docks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One scan: two planted runs either side of sample 'centre', over a background
   // of invalid samples and occasional noise.
   task automatic random_scan(input int centre, input int len_min, input int len_max);
      int          l1, l2, p1, p2, r1, r2, jit, len;
      bit          all_noise;
      logic [15:0] rng;
      logic        fin;
      l1 = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 24) : $urandom_range(4, 8);
      l2 = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 24) : $urandom_range(4, 8);
      p1 = centre + 1 + $urandom_range(0, 4);
      p2 = centre - l2 - $urandom_range(0, 4);
      if (p2 < 0) p2 = 0;
      r1 = $urandom_range(150, 800);
      r2 = r1 + $urandom_range(0, 80) - 40;
      jit = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
      all_noise = ($urandom_range(0, 9) == 0);
      len = $urandom_range(len_min, len_max);
      if (len < p1 + l1 + 1) len = p1 + l1 + 1;
      if ($urandom_range(0, 7) == 0) len = p1 + l1;   // scan ends inside the run
      steady_tx = ($urandom_range(0, 4) == 0);
      steady_rx = ($urandom_range(0, 4) == 0);
      clock_ms += $urandom_range(0, 120);
      if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
      for (int i = 0; i < len; i++) begin
         fin = 1'($urandom_range(0, 1));
         rng = 16'hFFFF;
         if (all_noise || $urandom_range(0, 15) == 0) begin
            rng = 16'($urandom_range(0, 65535));
            fin = ($urandom_range(0, 3) != 0);
         end else if (i >= p1 && i < p1 + l1) begin
            rng = 16'(r1 + $urandom_range(0, jit)); fin = 1;
         end else if (i >= p2 && i < p2 + l2) begin
            rng = 16'(r2 + $urandom_range(0, jit)); fin = 1;
         end
         send_sample(rng, fin, i == len - 1, (i == len - 1) ? clock_ms : $urandom,
                     1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_bus.ready <= 0; rx_hold--;
         end else if (rx_wait > 0) begin
            rsp_bus.ready <= 0; rx_wait--;
         end else begin
            rsp_bus.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      dock_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rx_wait = steady_rx ? 0 : $urandom_range(0, 3);
         if (expected_docks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result tv=%0b dist=%0d bear=%0d",
                        rsp_bus.target_valid, rsp_bus.distance_mm, rsp_bus.bearing);
         end else begin
            want = expected_docks.pop_front();
            if (rsp_bus.target_valid !== want.target_valid ||
                rsp_bus.distance_mm !== want.distance_mm ||
                rsp_bus.bearing !== want.bearing) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected tv=%0b dist=%0d bear=%0d, got tv=%0b dist=%0d bear=%0d",
                           want.target_valid, want.distance_mm, want.bearing,
                           rsp_bus.target_valid, rsp_bus.distance_mm, rsp_bus.bearing);
            end
         end
      end
   end

   // Watchdog: count cycles in which no transaction of any kind moves.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   dock_row_type directed_rows[10];

   initial begin
      clock = 0; reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      req_bus.valid = 0; req_bus.range_mm = 0; req_bus.range_finite = 0;
      req_bus.last_sample = 0; req_bus.now_ms = 0;
      mismatches = 0; sent = 0; idle_cycles = 0; rx_wait = 0; rx_hold = 0;
      steady_tx = 0; steady_rx = 0; clock_ms = 0;

      // reset values of the registers and a clean scan
      regs = '{16'd600, 16'd60, -16'sd32768, 16'd182, 16'd238, 16'd50, 15'd5461, 16'd150};
      scan_pos = 0; run_open = 0; run_first = 0; run_len = 0; run_total = 0; prev_mm = 0;
      left_ok = 0; left_mm = 0; left_ang = 0; right_ok = 0; right_mm = 0; right_ang = 0;
      hold_ok = 0; hold_dist = 0; hold_bear = 0; hold_stamp = 0;

      // Directed scans under reset settings. A lone sample, a right-only run,
      // range boundaries, and a wrapped time stamp. Typed rows give no target.
      directed_rows = '{
         '{16'd0,     1'b1, 1'b1, 32'd0,         1'b1, '0},
         '{16'd500,   1'b1, 1'b0, 32'd0,         1'b0, '0},
         '{16'd500,   1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
         '{16'd540,   1'b1, 1'b0, 32'h5555_AAAA, 1'b0, '0},
         '{16'd480,   1'b1, 1'b0, 32'd0,         1'b0, '0},
         '{16'hFFFF,  1'b1, 1'b0, 32'd0,         1'b0, '0},
         '{16'd599,   1'b0, 1'b0, 32'd0,         1'b0, '0},
         '{16'd600,   1'b1, 1'b0, 32'd0,         1'b0, '0},
         '{16'd599,   1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, '0},
         '{16'd0,     1'b0, 1'b1, 32'd149,       1'b1, '0}};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].range_mm, directed_rows[i].finite,
                     directed_rows[i].last, directed_rows[i].now_ms,
                     directed_rows[i].typed, directed_rows[i].res);
      drain();

      // Scan geometry: sample 32 faces straight ahead, 5.6 degrees per sample.
      write_all(16'd2000, 16'd60, 16'h8000, 16'd1024, 16'd238, 16'd50, 16'd5461, 16'd150);
      while (sent < 300) random_scan(32, 40, 64);
      // hold the receiver off while short scans keep coming, so the block backs up
      rx_hold = 400;
      while (sent < 450) random_scan(32, 38, 40);
      drain();
      while (sent < 650) random_scan(32, 40, 64);
      drain();

      // Wide-open extremes: no split tolerance, no lower bound, long hold.
      write_all(16'hFFFF, 16'd0, 16'h7FFF, 16'd1024, 16'd0, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      while (sent < 900) random_scan(32, 40, 64);
      drain();

      // Degenerate angles: every cluster sits at -32768 and counts as right.
      write_all(16'd2000, 16'hFFFF, 16'h8000, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      while (sent < 1000) random_scan(32, 40, 64);
      drain();
      reg_write(REG_MAX_RANGE, 16'd0);   // nothing is ever in range
      while (sent < 1080) random_scan(32, 40, 64);
      drain();

      // Back to reset settings, then ordinary scans.
      write_all(16'd600, 16'd60, 16'h8000, 16'd182, 16'd238, 16'd50, 16'd5461, 16'd150);
      while (sent < 1500) random_scan(32, 40, 64);

      @(negedge clock);
      req_bus.valid <= 0;
      while (expected_docks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_docks.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
